@@ rtl/mtaf_pkg.sv @@
// Shared types, constants and the step magnitude table for the frame decoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mtaf_pkg;

   // Frame layout
   localparam int HEADER_BYTES       = 16;
   localparam int CHANNEL_DATA_BYTES = 128;
   localparam int FRAME_BYTES        = HEADER_BYTES + 2 * CHANNEL_DATA_BYTES;
   localparam int POS_W              = $clog2(FRAME_BYTES + 1);

   // Step level range
   localparam int LEVEL_W   = 5;
   localparam int LEVEL_MAX = 31;
   localparam int MAG_W     = 13;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      OP_LOAD_STEP,
      OP_LOAD_HIST,
      OP_DECODE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] data;
   } cmd_type;

   // Front to back, through the queue
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qhead_type;

   // Magnitudes indexed by {level, code[2:0]}
   localparam logic [MAG_W-1:0] STEP_MAG [0:255] = '{
      13'd1,   13'd5,    13'd9,    13'd13,   13'd16,   13'd20,   13'd24,   13'd28,
      13'd2,   13'd6,    13'd11,   13'd15,   13'd20,   13'd24,   13'd29,   13'd33,
      13'd2,   13'd7,    13'd13,   13'd18,   13'd23,   13'd28,   13'd34,   13'd39,
      13'd3,   13'd9,    13'd15,   13'd21,   13'd28,   13'd34,   13'd40,   13'd46,
      13'd3,   13'd11,   13'd18,   13'd26,   13'd33,   13'd41,   13'd48,   13'd56,
      13'd4,   13'd13,   13'd22,   13'd31,   13'd40,   13'd49,   13'd58,   13'd67,
      13'd5,   13'd16,   13'd26,   13'd37,   13'd48,   13'd59,   13'd69,   13'd80,
      13'd6,   13'd19,   13'd31,   13'd44,   13'd57,   13'd70,   13'd82,   13'd95,
      13'd7,   13'd22,   13'd38,   13'd53,   13'd68,   13'd83,   13'd99,   13'd114,
      13'd9,   13'd27,   13'd45,   13'd63,   13'd81,   13'd99,   13'd117,  13'd135,
      13'd10,  13'd32,   13'd53,   13'd75,   13'd96,   13'd118,  13'd139,  13'd161,
      13'd12,  13'd38,   13'd64,   13'd90,   13'd115,  13'd141,  13'd167,  13'd193,
      13'd15,  13'd45,   13'd76,   13'd106,  13'd137,  13'd167,  13'd198,  13'd228,
      13'd18,  13'd54,   13'd91,   13'd127,  13'd164,  13'd200,  13'd237,  13'd273,
      13'd21,  13'd65,   13'd108,  13'd152,  13'd195,  13'd239,  13'd282,  13'd326,
      13'd25,  13'd77,   13'd129,  13'd181,  13'd232,  13'd284,  13'd336,  13'd388,
      13'd30,  13'd92,   13'd153,  13'd215,  13'd276,  13'd338,  13'd399,  13'd461,
      13'd36,  13'd109,  13'd183,  13'd256,  13'd329,  13'd402,  13'd476,  13'd549,
      13'd43,  13'd130,  13'd218,  13'd305,  13'd392,  13'd479,  13'd567,  13'd654,
      13'd52,  13'd156,  13'd260,  13'd364,  13'd468,  13'd572,  13'd676,  13'd780,
      13'd62,  13'd186,  13'd310,  13'd434,  13'd558,  13'd682,  13'd806,  13'd930,
      13'd73,  13'd221,  13'd368,  13'd516,  13'd663,  13'd811,  13'd958,  13'd1106,
      13'd87,  13'd263,  13'd439,  13'd615,  13'd790,  13'd966,  13'd1142, 13'd1318,
      13'd104, 13'd314,  13'd523,  13'd733,  13'd942,  13'd1152, 13'd1361, 13'd1571,
      13'd124, 13'd374,  13'd623,  13'd873,  13'd1122, 13'd1372, 13'd1621, 13'd1871,
      13'd148, 13'd445,  13'd743,  13'd1040, 13'd1337, 13'd1634, 13'd1932, 13'd2229,
      13'd177, 13'd531,  13'd885,  13'd1239, 13'd1593, 13'd1947, 13'd2301, 13'd2655,
      13'd210, 13'd632,  13'd1053, 13'd1475, 13'd1896, 13'd2318, 13'd2739, 13'd3161,
      13'd251, 13'd753,  13'd1255, 13'd1757, 13'd2260, 13'd2762, 13'd3264, 13'd3766,
      13'd299, 13'd897,  13'd1495, 13'd2093, 13'd2692, 13'd3290, 13'd3888, 13'd4486,
      13'd356, 13'd1068, 13'd1781, 13'd2493, 13'd3206, 13'd3918, 13'd4631, 13'd5343,
      13'd424, 13'd1273, 13'd2121, 13'd2970, 13'd3819, 13'd4668, 13'd5516, 13'd6365
   };

endpackage

`default_nettype wire

@@ rtl/mtaf_adpcm_frame_decoder_top.sv @@
// Frame ADPCM decoder top level: front end, command queue, back end.
// Flow: a data byte is written into the queue as it is accepted; the back end then
// decodes its low nibble and then its high nibble into the result register.
// Throughput: one byte per cycle accepted while the queue has room; the back end
// decodes one nibble per cycle while the result register is free and applies a
// header field load from the queue; other bytes never enter the queue.
// Reset (synchronous, active high) clears the channel select, position, header
// latch, history, level, queue and result valid flag; the result data is not reset.
`default_nettype none

module mtaf_adpcm_frame_decoder_top
   import mtaf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_we,
   input  wire logic [0:0]    csr_wdata,
   input  wire logic          req_push,
   output logic               req_full,
   input  wire logic [7:0]    req_frame_byte,
   input  wire logic          req_frame_start,
   output logic               rsp_empty,
   input  wire logic          rsp_pop,
   output logic signed [15:0] rsp_sample,
   output logic               rsp_last
);

   logic      accept;
   logic      cmd_push;
   cmd_type   cmd;
   qhead_type head;
   logic      q_pop;
   logic      q_full;
   logic      mid_byte;
   logic [15:0] sample;

   assign req_full   = q_full;
   assign accept     = req_push && !q_full;
   assign rsp_sample = sample;

   mtaf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .frame_byte  (req_frame_byte),
      .frame_start (req_frame_start),
      .cmd_push    (cmd_push),
      .cmd         (cmd)
   );

   mtaf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .pop      (q_pop),
      .full     (q_full),
      .head     (head)
   );

   mtaf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (q_pop),
      .mid_byte   (mid_byte),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_sample (sample),
      .rsp_last   (rsp_last)
   );

   // Nothing is waiting for the consumer straight after reset
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result waiting after reset");

   // Halfway through a byte the queue head must still be that data byte
   assert property (@(posedge clock) disable iff (reset)
      mid_byte |-> (head.valid && head.cmd.op == OP_DECODE))
      else $error("high nibble pending without a data command");

   // A new result lands only after a decode; low nibble is followed by high
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_last && rsp_pop) |-> mid_byte)
      else $error("low nibble sample taken with no high nibble pending");

endmodule

`default_nettype wire

@@ rtl/mtaf_front.sv @@
// Front end: tracks the byte position in the frame, latches header fields and
// turns bytes of the selected channel into decoder commands. Uses mtaf_pkg.
`default_nettype none

module mtaf_front
   import mtaf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic [0:0] csr_wdata,
   input  wire logic       accept,
   input  wire logic [7:0] frame_byte,
   input  wire logic       frame_start,
   output logic            cmd_push,
   output cmd_type         cmd
);

   localparam logic [POS_W-1:0] FRAME_END  = POS_W'(FRAME_BYTES);
   localparam logic [POS_W-1:0] HDR_END    = POS_W'(HEADER_BYTES);
   localparam logic [POS_W-1:0] DATA_LO_L  = POS_W'(HEADER_BYTES);
   localparam logic [POS_W-1:0] DATA_LO_R  = POS_W'(HEADER_BYTES + CHANNEL_DATA_BYTES);
   localparam logic [POS_W-1:0] DATA_LEN   = POS_W'(CHANNEL_DATA_BYTES);

   logic             chan_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       latch_ff, latch_in;

   logic [POS_W-1:0] pos;
   logic [POS_W-1:0] data_lo;
   logic [3:0]       hpos;
   logic [15:0]      word;
   logic             is_hdr;

   // Channel select register
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= 1'b0;
      end else if (csr_we) begin
         chan_ff <= csr_wdata[0];
      end
   end

   // Classify the byte
   always_comb begin
      pos      = frame_start ? '0 : pos_ff;
      data_lo  = chan_ff ? DATA_LO_R : DATA_LO_L;
      hpos     = pos[3:0];
      is_hdr   = (pos < HDR_END);
      word     = {frame_byte, latch_ff};
      latch_in = latch_ff;
      pos_in   = (pos < FRAME_END) ? pos + POS_W'(1) : pos;
      cmd_push = 1'b0;
      cmd.op   = OP_DECODE;
      cmd.data = {8'h00, frame_byte};
      if (is_hdr) begin
         if (hpos == (4'd4 + {2'b00, chan_ff, 1'b0}) ||
             hpos == (4'd8 + {1'b0, chan_ff, 2'b00})) begin
            latch_in = frame_byte;
         end else if (hpos == (4'd5 + {2'b00, chan_ff, 1'b0})) begin
            cmd_push = 1'b1;
            cmd.op   = OP_LOAD_STEP;
            // clamp signed index to 0..31
            if (word[15]) begin
               cmd.data = 16'd0;
            end else if (word > 16'(LEVEL_MAX)) begin
               cmd.data = 16'(LEVEL_MAX);
            end else begin
               cmd.data = word;
            end
         end else if (hpos == (4'd9 + {1'b0, chan_ff, 2'b00})) begin
            cmd_push = 1'b1;
            cmd.op   = OP_LOAD_HIST;
            cmd.data = word;
         end
      end else if (pos >= data_lo && (pos - data_lo) < DATA_LEN) begin
         cmd_push = 1'b1;
      end
      cmd_push = cmd_push & accept;
   end

   // Position and header latch
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         latch_ff <= 8'h00;
      end else if (accept) begin
         pos_ff   <= pos_in;
         latch_ff <= latch_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/mtaf_queue.sv @@
// Short command queue between the front and back ends.
// Uses mtaf_pkg for the command type and depth.
`default_nettype none

module mtaf_queue
   import mtaf_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  cmd_type   push_cmd,
   input  wire logic pop,
   output logic      full,
   output qhead_type head
);

   cmd_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W:0] wr_ff, wr_in;
   logic [QPTR_W:0] rd_ff, rd_in;
   logic            do_push, do_pop;

   always_comb begin
      full      = (wr_ff[QPTR_W] != rd_ff[QPTR_W]) &&
                  (wr_ff[QPTR_W-1:0] == rd_ff[QPTR_W-1:0]);
      head.valid = (wr_ff != rd_ff);
      head.cmd   = slot_ff[rd_ff[QPTR_W-1:0]];
      do_push    = push && !full;
      do_pop     = pop && head.valid;
      wr_in      = do_push ? wr_ff + (QPTR_W+1)'(1) : wr_ff;
      rd_in      = do_pop ? rd_ff + (QPTR_W+1)'(1) : rd_ff;
   end

   // Pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff[QPTR_W-1:0]] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

@@ rtl/mtaf_back.sv @@
// Back end: applies header loads and decodes data bytes one nibble per cycle
// into a result register while it is free; uses mtaf_pkg types, step table.
`default_nettype none

module mtaf_back
   import mtaf_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  qhead_type   head,
   output logic        pop,
   output logic        mid_byte,
   output logic        rsp_empty,
   input  wire logic   rsp_pop,
   output logic [15:0] rsp_sample,
   output logic        rsp_last
);

   logic [15:0]        hist_ff, hist_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               phase_ff, phase_in;
   logic               out_valid_ff, out_valid_in;
   logic [15:0]        sample_ff;
   logic               last_ff;

   logic               slot_free;
   logic               decode_now;
   logic [3:0]         code;
   logic [MAG_W-1:0]   mag;
   logic signed [16:0] sum;
   logic [15:0]        sat;
   logic signed [6:0]  move;
   logic signed [6:0]  lv;

   // Nibble arithmetic
   always_comb begin
      code = phase_ff ? head.cmd.data[7:4] : head.cmd.data[3:0];
      mag  = STEP_MAG[{level_ff, code[2:0]}];
      if (code[3]) begin
         sum = $signed({hist_ff[15], hist_ff}) - $signed({4'b0000, mag});
      end else begin
         sum = $signed({hist_ff[15], hist_ff}) + $signed({4'b0000, mag});
      end
      if (sum[16] != sum[15]) begin
         sat = sum[16] ? 16'h8000 : 16'h7fff;
      end else begin
         sat = sum[15:0];
      end
      if (code[2]) begin
         move = $signed({4'b0000, code[1:0], 1'b0}) + 7'sd2;
      end else begin
         move = -7'sd1;
      end
      lv = $signed({2'b00, level_ff}) + move;
   end

   // Command sequencing
   always_comb begin
      slot_free    = !out_valid_ff || rsp_pop;
      decode_now   = 1'b0;
      pop          = 1'b0;
      hist_in      = hist_ff;
      level_in     = level_ff;
      phase_in     = phase_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (head.valid) begin
         case (head.cmd.op)
            OP_LOAD_STEP: begin
               pop      = 1'b1;
               level_in = head.cmd.data[LEVEL_W-1:0];
            end
            OP_LOAD_HIST: begin
               pop     = 1'b1;
               hist_in = head.cmd.data;
            end
            OP_DECODE: begin
               if (slot_free) begin
                  decode_now   = 1'b1;
                  out_valid_in = 1'b1;
                  hist_in      = sat;
                  if (lv < 0) begin
                     level_in = '0;
                  end else if (lv > 7'(LEVEL_MAX)) begin
                     level_in = LEVEL_W'(LEVEL_MAX);
                  end else begin
                     level_in = lv[LEVEL_W-1:0];
                  end
                  phase_in = !phase_ff;
                  pop      = phase_ff;
               end
            end
            default: begin
               pop = 1'b1;
            end
         endcase
      end
   end

   // Decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff      <= 16'h0000;
         level_ff     <= '0;
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         hist_ff      <= hist_in;
         level_ff     <= level_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (decode_now) begin
         sample_ff <= sat;
         last_ff   <= phase_ff;
      end
   end

   assign mid_byte   = phase_ff;
   assign rsp_empty  = !out_valid_ff;
   assign rsp_sample = sample_ff;
   assign rsp_last   = last_ff;

endmodule

`default_nettype wire

@@ bench/mtaf_adpcm_frame_decoder_top_tb.sv @@
// Self-checking bench for the stereo frame ADPCM decoder top level: drives frame bytes
// through the input queue, predicts every PCM sample and checks each popped transaction.
// Depends on rtl/mtaf_pkg.sv for the frame layout and on the top-level RTL.
`timescale 1ns / 100ps

module mtaf_adpcm_frame_decoder_top_tb;

   // Frame layout, taken from the package
   localparam int HDR_LEN   = mtaf_pkg::HEADER_BYTES;
   localparam int CH_LEN    = mtaf_pkg::CHANNEL_DATA_BYTES;
   localparam int FRAME_LEN = mtaf_pkg::FRAME_BYTES;

   // Header field offsets; the right channel's fields sit further on
   localparam int STEP_LO_OFS = 4;
   localparam int HIST_LO_OFS = 8;

   // Bench timing
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 16;
   localparam int PRINT_CAP     = 200;

   // Step magnitudes per level, codes 0..7; bit 3 of the code negates
   localparam int MAG_TABLE [32][8] = '{
      '{1, 5, 9, 13, 16, 20, 24, 28},
      '{2, 6, 11, 15, 20, 24, 29, 33},
      '{2, 7, 13, 18, 23, 28, 34, 39},
      '{3, 9, 15, 21, 28, 34, 40, 46},
      '{3, 11, 18, 26, 33, 41, 48, 56},
      '{4, 13, 22, 31, 40, 49, 58, 67},
      '{5, 16, 26, 37, 48, 59, 69, 80},
      '{6, 19, 31, 44, 57, 70, 82, 95},
      '{7, 22, 38, 53, 68, 83, 99, 114},
      '{9, 27, 45, 63, 81, 99, 117, 135},
      '{10, 32, 53, 75, 96, 118, 139, 161},
      '{12, 38, 64, 90, 115, 141, 167, 193},
      '{15, 45, 76, 106, 137, 167, 198, 228},
      '{18, 54, 91, 127, 164, 200, 237, 273},
      '{21, 65, 108, 152, 195, 239, 282, 326},
      '{25, 77, 129, 181, 232, 284, 336, 388},
      '{30, 92, 153, 215, 276, 338, 399, 461},
      '{36, 109, 183, 256, 329, 402, 476, 549},
      '{43, 130, 218, 305, 392, 479, 567, 654},
      '{52, 156, 260, 364, 468, 572, 676, 780},
      '{62, 186, 310, 434, 558, 682, 806, 930},
      '{73, 221, 368, 516, 663, 811, 958, 1106},
      '{87, 263, 439, 615, 790, 966, 1142, 1318},
      '{104, 314, 523, 733, 942, 1152, 1361, 1571},
      '{124, 374, 623, 873, 1122, 1372, 1621, 1871},
      '{148, 445, 743, 1040, 1337, 1634, 1932, 2229},
      '{177, 531, 885, 1239, 1593, 1947, 2301, 2655},
      '{210, 632, 1053, 1475, 1896, 2318, 2739, 3161},
      '{251, 753, 1255, 1757, 2260, 2762, 3264, 3766},
      '{299, 897, 1495, 2093, 2692, 3290, 3888, 4486},
      '{356, 1068, 1781, 2493, 3206, 3918, 4631, 5343},
      '{424, 1273, 2121, 2970, 3819, 4668, 5516, 6365}
   };

   localparam int LEVEL_STEP [8] = '{-1, -1, -1, -1, 2, 4, 6, 8};

   typedef struct {
      logic signed [15:0] sample;
      logic               last;
   } pcm_word_type;

   // DUT connections
   logic               clock;
   logic               reset           = 1'b1;
   logic               csr_we          = 1'b0;
   logic [0:0]         csr_wdata       = 1'b0;
   logic               req_push        = 1'b0;
   logic [7:0]         req_frame_byte  = 8'h00;
   logic               req_frame_start = 1'b0;
   logic               rsp_pop         = 1'b0;
   wire                req_full;
   wire                rsp_empty;
   wire signed [15:0]  rsp_sample;
   wire                rsp_last;

   // Decoder state as the bench sees it
   logic [8:0]         mdl_pos   = '0;
   logic signed [15:0] mdl_hist  = '0;
   logic [4:0]         mdl_level = '0;
   logic [7:0]         head_lo   = '0;
   logic               mdl_chan  = 1'b0;

   pcm_word_type pending_pcm [$];
   int        sent_bytes  = 0;
   int        stop_at     = 0;
   int        error_count = 0;
   int        send_idle   = 0;
   int        recv_idle   = 0;
   int        stall_cycles = 0;

   mtaf_adpcm_frame_decoder_top DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_frame_byte  (req_frame_byte),
      .req_frame_start (req_frame_start),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_sample      (rsp_sample),
      .rsp_last        (rsp_last)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // One line per mismatch; the log is capped but every one is counted
   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_CAP)
         $display("%0t ns MISMATCH: %s", $time, msg);
      error_count++;
   endtask

   // One nibble: saturating history update and clamped level move
   task automatic apply_nibble(input logic [3:0] code, input logic high_half);
      int mag;
      int sum;
      int lv;
      mag = MAG_TABLE[mdl_level][code[2:0]];
      sum = int'(mdl_hist) + (code[3] ? -mag : mag);
      lv  = int'(mdl_level) + LEVEL_STEP[code[2:0]];
      if (sum > 32767)
         sum = 32767;
      else if (sum < -32768)
         sum = -32768;
      if (lv < 0)
         lv = 0;
      else if (lv > 31)
         lv = 31;
      mdl_level = lv[4:0];
      mdl_hist  = sum[15:0];
      pending_pcm.push_back('{sample: mdl_hist, last: high_half});
   endtask

   // Advance the frame position by one accepted byte and queue its samples
   task automatic decode_frame_byte(input logic [7:0] b, input logic st);
      logic signed [15:0] field;
      int data_lo;
      int step_ofs;
      int hist_ofs;
      field    = {b, head_lo};
      data_lo  = HDR_LEN + int'(mdl_chan) * CH_LEN;
      step_ofs = STEP_LO_OFS + 2 * int'(mdl_chan);
      hist_ofs = HIST_LO_OFS + 4 * int'(mdl_chan);
      if (st)
         mdl_pos = '0;
      if (mdl_pos < HDR_LEN) begin
         if (mdl_pos == step_ofs || mdl_pos == hist_ofs) begin
            head_lo = b;
         end else if (mdl_pos == step_ofs + 1) begin
            // out-of-range step index clamps to the table
            if (field < 0)
               mdl_level = '0;
            else if (field > 31)
               mdl_level = 5'd31;
            else
               mdl_level = field[4:0];
         end else if (mdl_pos == hist_ofs + 1) begin
            mdl_hist = field;
         end
      end else if (mdl_pos >= data_lo && mdl_pos < data_lo + CH_LEN) begin
         apply_nibble(b[3:0], 1'b0);
         apply_nibble(b[7:4], 1'b1);
      end
      if (mdl_pos < FRAME_LEN)
         mdl_pos++;
   endtask

   // Offer one byte, with random idling first, and wait for the transaction
   task automatic push_frame_byte(input logic [7:0] b, input logic st);
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push        <= 1'b1;
      req_frame_byte  <= b;
      req_frame_start <= st;
      do
         @(posedge clock);
      while (req_full);
      sent_bytes++;
      decode_frame_byte(b, st);
   endtask

   // Stop sending, let every sample out, settle, then write the channel select
   task automatic select_channel(input logic chan);
      req_push <= 1'b0;
      while (pending_pcm.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= chan;
      @(posedge clock);
      csr_we   <= 1'b0;
      mdl_chan  = chan;
   endtask

   // Step index word: negative, above the table, or in range
   function automatic logic [15:0] pick_step_word();
      case ($urandom_range(3))
         0:       return {1'b1, 15'($urandom_range(32767))};
         1:       return 16'($urandom_range(32767, 32));
         default: return 16'($urandom_range(31));
      endcase
   endfunction

   // One random sequence: full, truncated or overlong frame, or loose noise;
   // it is cut short once the byte budget of the test is spent
   task automatic send_frame_sequence();
      logic [15:0] step_word [2];
      logic [15:0] hist_word [2];
      logic [7:0]  b;
      logic        st;
      logic        loud;
      logic        noise;
      int          kind;
      int          len;
      kind  = $urandom_range(99);
      noise = 1'b0;
      if (kind < 65) begin
         len = FRAME_LEN;
      end else if (kind < 80) begin
         len = $urandom_range(FRAME_LEN - 1, 1);
      end else if (kind < 90) begin
         len = FRAME_LEN + $urandom_range(12, 1);
      end else begin
         len   = $urandom_range(20, 1);
         noise = 1'b1;
      end
      loud = ($urandom_range(3) == 0);
      for (int ch = 0; ch < 2; ch++) begin
         step_word[ch] = pick_step_word();
         hist_word[ch] = 16'($urandom_range(65535));
      end
      for (int i = 0; i < len && sent_bytes < stop_at; i++) begin
         st = noise ? ($urandom_range(15) == 0) : (i == 0);
         case (i)
            4:       b = step_word[0][7:0];
            5:       b = step_word[0][15:8];
            6:       b = step_word[1][7:0];
            7:       b = step_word[1][15:8];
            8:       b = hist_word[0][7:0];
            9:       b = hist_word[0][15:8];
            12:      b = hist_word[1][7:0];
            13:      b = hist_word[1][15:8];
            default: begin
               b = 8'($urandom_range(255));
               // large codes drive the history into saturation
               if (loud && i >= HDR_LEN)
                  b = b | 8'h66;
            end
         endcase
         push_frame_byte(b, st);
      end
   endtask

   // First frame after reset with no start flag: step index above the table,
   // history near the top, then large codes through both saturation limits
   task automatic test_unstarted_frame_clamps();
      logic [7:0] hdr [16];
      logic [7:0] dat [9];
      hdr = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h00, 8'h01, 8'hFF, 8'h7F,
              8'hF0, 8'h7F, 8'h12, 8'h34, 8'h00, 8'h80, 8'hC3, 8'h3C};
      dat = '{8'h77, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h08, 8'h80};
      foreach (hdr[i])
         push_frame_byte(hdr[i], 1'b0);
      foreach (dat[i])
         push_frame_byte(dat[i], 1'b0);
   endtask

   // Random sequences until the given number of bytes has gone in
   task automatic test_random_frames(input int target, input int s_idle, input int r_idle,
                                     input logic hop_channel);
      stop_at   = sent_bytes + target;
      send_idle = s_idle;
      recv_idle = r_idle;
      while (sent_bytes < stop_at) begin
         if (hop_channel)
            select_channel(1'($urandom_range(1)));
         send_frame_sequence();
      end
   endtask

   // Pop side: check each accepted transaction, then pick the next pop
   initial begin
      pcm_word_type exp_word;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (pending_pcm.size() == 0) begin
               report_mismatch($sformatf("sample %0d last %0b with none due",
                                         rsp_sample, rsp_last));
            end else begin
               exp_word = pending_pcm.pop_front();
               if (rsp_sample !== exp_word.sample)
                  report_mismatch($sformatf("sample %0d, due %0d",
                                            rsp_sample, exp_word.sample));
               if (rsp_last !== exp_word.last)
                  report_mismatch($sformatf("last %0b, due %0b",
                                            rsp_last, exp_word.last));
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_idle);
      end
   end

   // Watchdog: too long with no transaction on either side ends the run
   initial begin
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("mtaf_adpcm_frame_decoder_top_tb: errors");
      $finish;
   end

   // Test sequence
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      select_channel(1'b0);
      test_unstarted_frame_clamps();
      select_channel(1'b1);
      test_random_frames(340, 32, 70, 1'b0);
      select_channel(1'b0);
      test_random_frames(340, 70, 32, 1'b0);
      test_random_frames(340, 0, 0, 1'b1);

      // drain and let the pipeline run dry
      req_push <= 1'b0;
      while (pending_pcm.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_pcm.size() != 0)
         report_mismatch($sformatf("%0d samples never arrived", pending_pcm.size()));

      if (error_count == 0)
         $display("mtaf_adpcm_frame_decoder_top_tb: clean");
      else
         $display("mtaf_adpcm_frame_decoder_top_tb: errors");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/mtaf_pkg.sv
rtl/mtaf_front.sv
rtl/mtaf_queue.sv
rtl/mtaf_back.sv
rtl/mtaf_adpcm_frame_decoder_top.sv
bench/mtaf_adpcm_frame_decoder_top_tb.sv
